// ===== rtl/core/vn_pkg.sv =====
package vn_pkg;

    // Control passed to the square root and divider pipelines: a global advance and the entering valid.
    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;

endpackage

// ===== rtl/core/vn_sqrt.sv =====
module vn_sqrt #(
    parameter int CW = 16,
    parameter int PW = 51
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  vn_pkg::t_stage_ctl    i_ctl,
    input  logic [2*CW-1:0]       i_sum,
    input  logic [PW-1:0]         i_pay,
    output logic                  o_valid,
    output logic [CW-1:0]         o_root,
    output logic [PW-1:0]         o_pay
);
    localparam int RMW = CW + 2;

    logic [RMW-1:0]  r_rem  [CW];
    logic [CW-1:0]   r_root [CW];
    logic [2*CW-1:0] r_sum  [CW];
    logic [PW-1:0]   r_pay  [CW];
    logic            r_vld  [CW];

    for (genvar g = 0; g < CW; g++) begin : g_stg
        localparam int B = CW - 1 - g;
        logic [RMW-1:0]  p_rem;
        logic [CW-1:0]   p_root;
        logic [2*CW-1:0] p_sum;
        logic [PW-1:0]   p_pay;
        logic            p_vld;
        logic [RMW-1:0]  rem_sh;
        logic [RMW-1:0]  trial;
        logic            take;

        if (g == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_sum  = i_sum;
            assign p_pay  = i_pay;
            assign p_vld  = i_ctl.valid;
        end else begin : g_next
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_sum  = r_sum[g-1];
            assign p_pay  = r_pay[g-1];
            assign p_vld  = r_vld[g-1];
        end

        // Bring down the next two bits of the radicand and try root bit one.
        assign rem_sh = {p_rem[RMW-3:0], p_sum[2*B+1 -: 2]};
        assign trial  = {p_root, 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[g]  <= take ? rem_sh - trial : rem_sh;
                r_root[g] <= {p_root[CW-2:0], take};
                r_sum[g]  <= p_sum;
                r_pay[g]  <= p_pay;
            end
        end
    end

    assign o_valid = r_vld[CW-1];
    assign o_root  = r_root[CW-1];
    assign o_pay   = r_pay[CW-1];

endmodule

// ===== rtl/core/vn_div.sv =====
module vn_div #(
    parameter int CW  = 16,
    parameter int UFB = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  vn_pkg::t_stage_ctl    i_ctl,
    input  logic [CW-1:0]         i_mag,
    input  logic                  i_neg,
    input  logic [CW-1:0]         i_len,
    output logic                  o_valid,
    output logic [UFB:0]          o_quo,
    output logic                  o_neg,
    output logic [CW-1:0]         o_len
);
    localparam int NS = UFB + 1;

    logic [CW:0]   r_rem [NS];
    logic [UFB:0]  r_quo [NS];
    logic [CW-1:0] r_len [NS];
    logic          r_neg [NS];
    logic          r_vld [NS];

    // Magnitude never exceeds the length, so the remainder stays below it
    // and the quotient fits in UFB+1 bits.
    for (genvar g = 0; g < NS; g++) begin : g_stg
        logic [CW:0]   p_rem;
        logic [UFB:0]  p_quo;
        logic [CW-1:0] p_len;
        logic          p_neg;
        logic          p_vld;
        logic          take;

        if (g == 0) begin : g_first
            assign p_rem = {1'b0, i_mag};
            assign p_quo = '0;
            assign p_len = i_len;
            assign p_neg = i_neg;
            assign p_vld = i_ctl.valid;
        end else begin : g_next
            assign p_rem = {r_rem[g-1][CW-1:0], 1'b0};
            assign p_quo = r_quo[g-1];
            assign p_len = r_len[g-1];
            assign p_neg = r_neg[g-1];
            assign p_vld = r_vld[g-1];
        end

        assign take = (p_rem >= {1'b0, p_len});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[g] <= take ? p_rem - {1'b0, p_len} : p_rem;
                r_quo[g] <= {p_quo[UFB-1:0], take};
                r_len[g] <= p_len;
                r_neg[g] <= p_neg;
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_quo   = r_quo[NS-1];
    assign o_neg   = r_neg[NS-1];
    assign o_len   = r_len[NS-1];

endmodule

// ===== rtl/core/vec3_normalize.sv =====
// Channel  | Direction | Handshake          | Payload
// input    | in        | i_valid / o_stall  | i_in_x, i_in_y, i_in_z
// output   | out       | o_valid / i_stall  | o_unit_x/y/z, o_length, o_zero_vector
//
// One transaction per cycle while the output is not stalled. Registered stages in order:
// magnitude, squares, sum, the square root pipeline and the divider pipelines, which
// settle the root and the quotients one bit per stage, and an output stage.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
// A stalled output holds the whole pipeline; o_stall follows that hold.
module vec3_normalize #(
    parameter int COMPONENT_WIDTH    = 16,
    parameter int UNIT_FRACTION_BITS = 14
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [COMPONENT_WIDTH-1:0]    i_in_x,
    input  logic signed [COMPONENT_WIDTH-1:0]    i_in_y,
    input  logic signed [COMPONENT_WIDTH-1:0]    i_in_z,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [UNIT_FRACTION_BITS+1:0] o_unit_x,
    output logic signed [UNIT_FRACTION_BITS+1:0] o_unit_y,
    output logic signed [UNIT_FRACTION_BITS+1:0] o_unit_z,
    output logic        [COMPONENT_WIDTH-1:0]    o_length,
    output logic                                 o_zero_vector
);
    localparam int CW  = COMPONENT_WIDTH;
    localparam int UFB = UNIT_FRACTION_BITS;
    localparam int UW  = UFB + 2;
    localparam int PW  = 3 * (CW + 1);

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    logic [CW-1:0] in_c [3];
    assign in_c[0] = i_in_x;
    assign in_c[1] = i_in_y;
    assign in_c[2] = i_in_z;

    // Magnitude stage
    logic          r_a_vld;
    logic [CW-1:0] r_a_mag [3];
    logic          r_a_neg [3];
    // Square stage
    logic            r_b_vld;
    logic [2*CW-1:0] r_b_sq  [3];
    logic [CW-1:0]   r_b_mag [3];
    logic            r_b_neg [3];
    // Sum stage
    logic            r_c_vld;
    logic [2*CW-1:0] r_c_sum;
    logic [PW-1:0]   r_c_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_a_neg[k] <= in_c[k][CW-1];
                r_a_mag[k] <= in_c[k][CW-1] ? (~in_c[k] + 1'b1) : in_c[k];
                r_b_sq[k]  <= (2*CW)'(r_a_mag[k]) * (2*CW)'(r_a_mag[k]);
                r_b_mag[k] <= r_a_mag[k];
                r_b_neg[k] <= r_a_neg[k];
            end
            r_c_sum <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
            r_c_pay <= {r_b_neg[2], r_b_mag[2], r_b_neg[1], r_b_mag[1],
                        r_b_neg[0], r_b_mag[0]};
        end
    end

    vn_pkg::t_stage_ctl sq_ctl;
    assign sq_ctl.en    = en;
    assign sq_ctl.valid = r_c_vld;

    logic          sq_vld;
    logic [CW-1:0] sq_root;
    logic [PW-1:0] sq_pay;

    vn_sqrt #(.CW(CW), .PW(PW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sq_ctl),
        .i_sum   (r_c_sum),
        .i_pay   (r_c_pay),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_pay   (sq_pay)
    );

    vn_pkg::t_stage_ctl dv_ctl;
    assign dv_ctl.en    = en;
    assign dv_ctl.valid = sq_vld;

    logic          dv_vld [3];
    logic [UFB:0]  dv_quo [3];
    logic          dv_neg [3];
    logic [CW-1:0] dv_len [3];

    for (genvar k = 0; k < 3; k++) begin : g_lane
        vn_div #(.CW(CW), .UFB(UFB)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (dv_ctl),
            .i_mag   (sq_pay[k*(CW+1) +: CW]),
            .i_neg   (sq_pay[k*(CW+1) + CW]),
            .i_len   (sq_root),
            .o_valid (dv_vld[k]),
            .o_quo   (dv_quo[k]),
            .o_neg   (dv_neg[k]),
            .o_len   (dv_len[k])
        );
    end

    logic          r_o_vld;
    logic [UW-1:0] r_o_unit [3];
    logic [CW-1:0] r_o_len;
    logic          r_o_zero;
    logic          zero;
    logic [UW-1:0] q_ext [3];

    assign zero = (dv_len[0] == '0);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            q_ext[k] = {1'b0, dv_quo[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= dv_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                // drop the quotient for a zero vector
                r_o_unit[k] <= zero ? '0 : (dv_neg[k] ? (~q_ext[k] + 1'b1) : q_ext[k]);
            end
            r_o_len  <= dv_len[0];
            r_o_zero <= zero;
        end
    end

    assign o_valid       = r_o_vld;
    assign o_unit_x      = r_o_unit[0];
    assign o_unit_y      = r_o_unit[1];
    assign o_unit_z      = r_o_unit[2];
    assign o_length      = r_o_len;
    assign o_zero_vector = r_o_zero;

    a_zero_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_vector |-> o_unit_x == '0 && o_unit_y == '0 && o_unit_z == '0)
        else $error("zero vector with nonzero unit components");

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_zero_vector == (o_length == '0))
        else $error("zero flag disagrees with length");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_length) && $stable(o_unit_x))
        else $error("stalled transaction changed");

    a_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_vld[0] == dv_vld[1] && dv_vld[1] == dv_vld[2] &&
        (!dv_vld[0] || (dv_len[0] == dv_len[1] && dv_len[1] == dv_len[2])))
        else $error("divider lanes out of step");

endmodule

// ===== tb/testbench.sv =====
module testbench;

    localparam int CW  = 16;
    localparam int UFB = 14;
    localparam int UW  = UFB + 2;
    localparam int LATENCY = CW + UFB + 5;

    typedef struct packed {
        logic signed [UW-1:0] ux;
        logic signed [UW-1:0] uy;
        logic signed [UW-1:0] uz;
        logic [CW-1:0]        len;
        logic                 zero;
    } norm_t;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 known;
        norm_t                want;
    } vec_row_t;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_valid = 0;
    logic                 o_stall;
    logic signed [CW-1:0] i_in_x = '0;
    logic signed [CW-1:0] i_in_y = '0;
    logic signed [CW-1:0] i_in_z = '0;
    logic                 o_valid;
    logic                 i_stall = 0;
    logic signed [UW-1:0] o_unit_x, o_unit_y, o_unit_z;
    logic [CW-1:0]        o_length;
    logic                 o_zero_vector;

    norm_t    pending_norms[$];
    int       n_errors = 0;
    int       n_results = 0;
    int       n_zero = 0;
    bit       hold_long = 0;
    bit       sent_all = 0;
    vec_row_t vec_table[$];

    vec3_normalize u_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned floor_sqrt(longint unsigned s);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= root + bitv) begin
                s -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic signed [UW-1:0] scale_to_unit(logic signed [CW-1:0] c,
                                                           longint unsigned len);
        longint q;
        if (len == 0) return '0;
        q = (longint'(c) < 0 ? -longint'(c) : longint'(c));
        q = (q << UFB) / longint'(len);
        if (c < 0) q = -q;
        return q[UW-1:0];
    endfunction

    function automatic norm_t normalize(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                        logic signed [CW-1:0] z);
        norm_t           r;
        longint unsigned len;
        len = floor_sqrt(longint'(x) * x + longint'(y) * y + longint'(z) * z);
        r.ux   = scale_to_unit(x, len);
        r.uy   = scale_to_unit(y, len);
        r.uz   = scale_to_unit(z, len);
        r.len  = len[CW-1:0];
        r.zero = (len == 0);
        return r;
    endfunction

    function automatic vec_row_t row(int x, int y, int z, bit known = 0,
                                     int ux = 0, int uy = 0, int uz = 0,
                                     int len = 0, bit zero = 0);
        vec_row_t r;
        r.x = CW'(x); r.y = CW'(y); r.z = CW'(z); r.known = known;
        r.want.ux = UW'(ux); r.want.uy = UW'(uy); r.want.uz = UW'(uz);
        r.want.len = CW'(len); r.want.zero = zero;
        return r;
    endfunction

    // Offer one transaction, hold until accepted.
    task automatic send_vec(vec_row_t r);
        norm_t p;
        p = r.known ? r.want : normalize(r.x, r.y, r.z);
        if (r.known && p != normalize(r.x, r.y, r.z))
            $error("directed row %0d,%0d,%0d disagrees with predictor", r.x, r.y, r.z);
        i_in_x <= r.x; i_in_y <= r.y; i_in_z <= r.z;
        i_valid <= 1;
        do @(posedge i_clk); while (o_stall);
        pending_norms.push_back(p);
        @(negedge i_clk);
    endtask

    task automatic sender_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
            ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
        if (n > 0) begin
            i_valid <= 0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    function automatic logic signed [CW-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? CW'(-32768) : CW'(32767);
            1: return CW'($urandom_range(0, 1) ? 0 : $urandom_range(0, 1) ? 1 : -1);
            2: return CW'($signed($urandom_range(0, 15)) - 8);
            default: return CW'($urandom);
        endcase
    endfunction

    initial begin
        vec_table.push_back(row(0, 0, 0, 1, 0, 0, 0, 0, 1));
        vec_table.push_back(row(256, 0, 0, 1, 16384, 0, 0, 256, 0));
        vec_table.push_back(row(0, -256, 0, 1, 0, -16384, 0, 256, 0));
        vec_table.push_back(row(0, 0, 256, 1, 0, 0, 16384, 256, 0));
        vec_table.push_back(row(-32768, 0, 0, 1, -16384, 0, 0, 32768, 0));
        vec_table.push_back(row(32767, 0, 0, 1, 16384, 0, 0, 32767, 0));
        vec_table.push_back(row(0, 0, 1, 1, 0, 0, 16384, 1, 0));
        vec_table.push_back(row(-1, 0, 0, 1, -16384, 0, 0, 1, 0));
        vec_table.push_back(row(-32768, -32768, -32768));
        vec_table.push_back(row(32767, 32767, 32767));
        vec_table.push_back(row(-32768, 32767, -32768));
        vec_table.push_back(row(3, 4, 0));
        vec_table.push_back(row(1, 1, 1));
        vec_table.push_back(row(-1, 1, -1));
        vec_table.push_back(row(768, -1024, 0));
        vec_table.push_back(row(12345, -6789, 4242));
        vec_table.push_back(row(-21846, 21845, -1));
        vec_table.push_back(row(0, 0, -32768));
        vec_table.push_back(row(16'h5555, 16'hAAAA, 16'h0F0F));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        foreach (vec_table[k]) send_vec(vec_table[k]);
        for (int k = 0; k < 500; k++) begin
            if (k == 150) hold_long = 1;
            if (k == 300) begin
                i_valid <= 0;
                wait (pending_norms.size() == 0);
                @(negedge i_clk);
            end
            send_vec(row(rand_comp(), rand_comp(), rand_comp()));
            if (k < 120 || k > 200) sender_gap();
        end
        i_valid <= 0;
        sent_all = 1;
    end

    // Receiver: random stall, one long hold while the sender keeps offering.
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                hold_long = 0;
                i_stall <= 1;
                repeat (3 * LATENCY) @(negedge i_clk);
            end
            n = $urandom_range(0, 19);
            if (n < 8) i_stall <= 0;
            else if (n < 18) i_stall <= $urandom_range(0, 1);
            else begin
                i_stall <= 1;
                repeat ($urandom_range(5, 40)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        norm_t w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_norms.size() == 0) begin
                $error("result with no vector pending");
                n_errors++;
            end else begin
                w = pending_norms.pop_front();
                n_results++;
                if (w.zero) n_zero++;
                if (o_unit_x !== w.ux) begin
                    $error("unit_x exp %0d got %0d", w.ux, o_unit_x); n_errors++;
                end
                if (o_unit_y !== w.uy) begin
                    $error("unit_y exp %0d got %0d", w.uy, o_unit_y); n_errors++;
                end
                if (o_unit_z !== w.uz) begin
                    $error("unit_z exp %0d got %0d", w.uz, o_unit_z); n_errors++;
                end
                if (o_length !== w.len) begin
                    $error("length exp %0d got %0d", w.len, o_length); n_errors++;
                end
                if (o_zero_vector !== w.zero) begin
                    $error("zero_vector exp %0b got %0b", w.zero, o_zero_vector);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        wait (sent_all);
        wait (pending_norms.size() == 0);
        repeat (2 * LATENCY) @(posedge i_clk);
        $display("normalized %0d vectors (%0d zero), directed extremes and random mix",
                 n_results, n_zero);
        if (n_errors == 0 && pending_norms.size() == 0) $display("testbench: done, clean");
        else $display("testbench: done, errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
